// ----- rtl/spc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the stepper position controller.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int SPC_POS_BITS = 16;
    localparam int NUM_BITS     = 24;
    localparam int PCT_BITS     = 8;
    localparam int HALF_BITS    = 16;

    localparam logic [NUM_BITS-1:0]  NUM_RESET       = 24'd60000;
    localparam logic [HALF_BITS-1:0] HALF_PERIOD_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_SELECT = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [7:0] CODE_SET_TARGET  = 8'd240;
    localparam logic [7:0] CODE_SET_CURRENT = 8'd241;
    localparam logic [7:0] REPLY_TARGET     = 8'd5;
    localparam logic [7:0] REPLY_CURRENT    = 8'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic take;
        logic div_start;
        logic finish;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic rise;
        logic div_done;
    } t_dp_status;

endpackage

// ----- rtl/spc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [spc_pkg::NUM_BITS-1:0] i_num,
    input  logic [spc_pkg::PCT_BITS-1:0] i_den,
    output logic                         o_done,
    output logic [spc_pkg::NUM_BITS-1:0] o_quo
);
    import spc_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [NUM_BITS-1:0] r_quo, n_quo;
    logic [PCT_BITS-1:0] r_rem, n_rem;
    logic [PCT_BITS-1:0] r_den, n_den;
    logic [PCT_BITS:0]   w_trial;
    logic [PCT_BITS:0]   w_diff;

    assign w_trial = {r_rem, r_quo[NUM_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CNT_BITS'(NUM_BITS - 1);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_diff[PCT_BITS-1:0];
                n_quo = {r_quo[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial[PCT_BITS-1:0];
                n_quo = {r_quo[NUM_BITS-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/spc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_dp
// Datapath: frame decode, position and timer state, divider, result register.
// ----------------------------------------------------------------------------
module spc_dp #(
    parameter int POS_BITS = spc_pkg::SPC_POS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [spc_pkg::NUM_BITS-1:0] i_cfg_data,
    input  logic [1:0]                   i_cmd,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_select_level,
    input  spc_pkg::t_ctrl_cmd           i_ctrl,
    output spc_pkg::t_dp_status          o_status,
    output logic                         o_step_out,
    output logic                         o_direction_out,
    output logic                         o_motor_enable,
    output logic                         o_moving,
    output logic [7:0]                   o_tx_byte,
    output logic signed [15:0]           o_position
);
    import spc_pkg::*;

    localparam int POS_EXT = (POS_BITS > 16) ? POS_BITS : 16;

    logic [NUM_BITS-1:0]  r_num;
    logic                 r_sel, n_sel;
    logic [2:0]           r_idx, n_idx;
    logic [7:0]           r_fb [4];
    logic [7:0]           n_fb [4];
    logic [POS_BITS-1:0]  r_cur, n_cur;
    logic [POS_BITS-1:0]  r_tgt, n_tgt;
    logic [PCT_BITS-1:0]  r_pct, n_pct;
    logic [HALF_BITS-1:0] r_half, n_half;
    logic [HALF_BITS-1:0] r_tick, n_tick;
    logic                 r_dir, n_dir;
    logic                 r_mov, n_mov;
    logic                 r_tmr, n_tmr;
    logic                 r_step, n_step;
    logic                 r_drv, n_drv;
    logic [7:0]           r_reply, n_reply;

    logic                 r_o_step, r_o_dir, r_o_drv, r_o_mov;
    logic [7:0]           r_o_tx;
    logic [15:0]          r_o_pos;

    logic [POS_EXT-1:0]   w_cur_ext;
    logic [POS_EXT-1:0]   w_next_ext;
    logic [HALF_BITS:0]   w_tick_inc;
    logic                 w_div_done;
    logic [NUM_BITS-1:0]  w_quo;

    spc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (r_num),
        .i_den   (r_pct),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_status.rise     = (i_cmd == CMD_SELECT) && i_select_level && !r_sel;
    assign o_status.div_done = w_div_done;

    assign w_cur_ext  = POS_EXT'(r_cur);
    assign w_next_ext = POS_EXT'(n_cur);
    assign w_tick_inc = {1'b0, r_tick} + (HALF_BITS+1)'(1);

    always_comb begin
        n_sel   = r_sel;
        n_idx   = r_idx;
        n_fb    = r_fb;
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_pct   = r_pct;
        n_half  = r_half;
        n_tick  = r_tick;
        n_dir   = r_dir;
        n_mov   = r_mov;
        n_tmr   = r_tmr;
        n_step  = r_step;
        n_drv   = r_drv;
        n_reply = r_reply;
        if (i_ctrl.take) begin
            case (i_cmd)
                CMD_BYTE: begin
                    if (r_sel) begin
                        case (r_idx)
                            3'd0: begin
                                n_reply = w_cur_ext[15:8];
                                n_idx   = 3'd1;
                            end
                            3'd1: begin
                                n_reply = w_cur_ext[7:0];
                                n_idx   = 3'd2;
                            end
                            3'd2: begin
                                n_reply = {7'd0, r_mov};
                                n_idx   = 3'd0;
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        if (r_idx < 3'd4) begin
                            n_fb[r_idx[1:0]] = i_rx_byte;
                            n_idx            = r_idx + 3'd1;
                            n_reply          = {5'd0, r_idx + 3'd1};
                        end
                        if (n_idx == 3'd4) begin
                            if (n_fb[0] == CODE_SET_TARGET) begin
                                n_reply = REPLY_TARGET;
                                n_tgt   = POS_BITS'({n_fb[1], n_fb[2]});
                                n_pct   = n_fb[3];
                            end else if (n_fb[0] == CODE_SET_CURRENT) begin
                                n_reply = REPLY_CURRENT;
                                n_cur   = POS_BITS'({n_fb[1], n_fb[2]});
                                n_tgt   = POS_BITS'({n_fb[1], n_fb[2]});
                            end
                        end
                    end
                end
                CMD_SELECT: begin
                    if (i_select_level != r_sel) begin
                        n_sel = i_select_level;
                        n_idx = 3'd0;
                        n_fb  = '{default: 8'd0};
                        if (!i_select_level) begin
                            n_tmr = 1'b0;
                            n_drv = 1'b0;
                            n_mov = 1'b0;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_tmr && r_sel) begin
                        if (w_tick_inc < {1'b0, r_half}) begin
                            n_tick = w_tick_inc[HALF_BITS-1:0];
                        end else begin
                            n_tick = '0;
                            if (r_step) begin
                                n_step = 1'b0;
                            end else begin
                                n_step = 1'b1;
                                if (r_dir) begin
                                    n_cur = r_cur + POS_BITS'(1);
                                end else begin
                                    n_cur = r_cur - POS_BITS'(1);
                                end
                                if (n_cur == r_tgt) begin
                                    n_tmr = 1'b0;
                                    n_drv = 1'b0;
                                    n_mov = 1'b0;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctrl.finish) begin
            if ((r_pct == '0) || (w_quo[NUM_BITS-1:HALF_BITS] != '0)) begin
                n_half = HALF_PERIOD_MAX;
            end else begin
                n_half = w_quo[HALF_BITS-1:0];
            end
            if (r_cur == r_tgt) begin
                n_mov = 1'b0;
            end else begin
                n_dir  = ($signed(r_cur) < $signed(r_tgt));
                n_tick = '0;
                n_mov  = 1'b1;
                n_tmr  = 1'b1;
                n_drv  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= NUM_RESET;
            r_sel   <= 1'b1;
            r_idx   <= 3'd0;
            r_fb    <= '{default: 8'd0};
            r_cur   <= '0;
            r_tgt   <= '0;
            r_pct   <= '0;
            r_half  <= '0;
            r_tick  <= '0;
            r_dir   <= 1'b0;
            r_mov   <= 1'b0;
            r_tmr   <= 1'b0;
            r_step  <= 1'b0;
            r_drv   <= 1'b0;
            r_reply <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_data;
            end
            r_sel   <= n_sel;
            r_idx   <= n_idx;
            r_fb    <= n_fb;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_pct   <= n_pct;
            r_half  <= n_half;
            r_tick  <= n_tick;
            r_dir   <= n_dir;
            r_mov   <= n_mov;
            r_tmr   <= n_tmr;
            r_step  <= n_step;
            r_drv   <= n_drv;
            r_reply <= n_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_o_step <= n_step;
            r_o_dir  <= n_dir;
            r_o_drv  <= n_drv;
            r_o_mov  <= n_mov;
            r_o_tx   <= n_reply;
            r_o_pos  <= w_next_ext[15:0];
        end
    end

    assign o_step_out      = r_o_step;
    assign o_direction_out = r_o_dir;
    assign o_motor_enable  = r_o_drv;
    assign o_moving        = r_o_mov;
    assign o_tx_byte       = r_o_tx;
    assign o_position      = $signed(r_o_pos);

endmodule

// ----- rtl/spc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ctrl
// Controller: input handshake, divider sequencing and result valid flag.
// ----------------------------------------------------------------------------
module spc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  spc_pkg::t_dp_status  i_status,
    output spc_pkg::t_ctrl_cmd   o_ctrl
);
    import spc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;
    logic   w_accept;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = (r_state == ST_IDLE) && w_slot_free && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_status.rise) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_ctrl.take      = 1'b0;
        o_ctrl.div_start = 1'b0;
        o_ctrl.finish    = 1'b0;
        o_ctrl.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = w_slot_free;
                o_ctrl.take      = w_accept;
                o_ctrl.div_start = w_accept && i_status.rise;
                o_ctrl.out_load  = w_accept && !i_status.rise;
            end
            ST_DIV: begin
            end
            ST_FIN: begin
                o_ctrl.finish   = w_slot_free;
                o_ctrl.out_load = w_slot_free;
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = o_ctrl.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_ctrl.out_load)
        else $error("result register loaded while a result is pending");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input accepted during a division");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.div_start |=> (r_state == ST_DIV))
        else $error("division start did not enter the divide state");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.finish |=> o_out_valid)
        else $error("finished move setup produced no result");

endmodule

// ----- rtl/stepper_position_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_controller
// Step/direction position controller driven by framed serial byte events.
// ----------------------------------------------------------------------------
// Each input item is one event: a serial byte, a select level change or a
// timer tick. Every accepted item yields exactly one result item holding the
// step, direction, enable and moving levels, the reply byte and the position.
// Input and output use valid/ready. A result is registered and appears the
// cycle after its item is accepted, so items flow at one per cycle while the
// receiver keeps ready high and no division runs. A rising select edge runs
// the half-period division in a bit-serial divider, one quotient bit per
// cycle; no input is taken until that item's result is loaded. The speed
// numerator is written through i_cfg_we and i_cfg_data only while the block
// is idle, a user's rule the block does not enforce. Synchronous active-low
// reset sets select high and the numerator to its reset value, and clears
// all other state but the result and divider data, with no clearing pass.
// A stalled receiver leaves input not ready until the held result is taken.
// ----------------------------------------------------------------------------
module stepper_position_controller #(
    parameter int POS_BITS = spc_pkg::SPC_POS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [spc_pkg::NUM_BITS-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_select_level,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_step_out,
    output logic                         o_direction_out,
    output logic                         o_motor_enable,
    output logic                         o_moving,
    output logic [7:0]                   o_tx_byte,
    output logic signed [15:0]           o_position
);
    import spc_pkg::*;

    t_ctrl_cmd  w_ctrl;
    t_dp_status w_status;

    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_ctrl      (w_ctrl)
    );

    spc_dp #(
        .POS_BITS (POS_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_select_level  (i_select_level),
        .i_ctrl          (w_ctrl),
        .o_status        (w_status),
        .o_step_out      (o_step_out),
        .o_direction_out (o_direction_out),
        .o_motor_enable  (o_motor_enable),
        .o_moving        (o_moving),
        .o_tx_byte       (o_tx_byte),
        .o_position      (o_position)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper position controller testbench
// Drives event items (serial bytes, select changes, timer ticks) into the
// controller and predicts every result item in a scoreboard that keeps its
// own copy of the frame, motion and timer state. Results are checked field by
// field in order. Both handshakes idle at random outside the calm phase, and
// the speed numerator is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        step;
    logic        dir;
    logic        enable;
    logic        moving;
    logic [7:0]  tx;
    logic [15:0] pos;
} t_motor_status;

class motor_scoreboard;
    logic [23:0]     numerator;
    logic            sel_high;
    logic [2:0]      idx;
    logic [3:0][7:0] frame;
    logic [15:0]     cur_pos;
    logic [15:0]     tgt_pos;
    logic [15:0]     half;
    logic [7:0]      pct;
    logic [16:0]     ticks;
    logic            dir;
    logic            mov;
    logic            timer_on;
    logic            step;
    logic            drive;
    logic [7:0]      reply;
    t_motor_status   status_q[$];
    int              errors;

    function new();
        numerator = spc_pkg::NUM_RESET;
        sel_high  = 1'b1;
        idx       = '0;
        frame     = '0;
        cur_pos   = '0;
        tgt_pos   = '0;
        half      = '0;
        pct       = '0;
        ticks     = '0;
        dir       = 1'b0;
        mov       = 1'b0;
        timer_on  = 1'b0;
        step      = 1'b0;
        drive     = 1'b0;
        reply     = '0;
        errors    = 0;
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    function void halt_motor();
        timer_on = 1'b0;
        drive    = 1'b0;
        mov      = 1'b0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] b, logic s);
        logic [31:0] quo;
        case (cmd)
            spc_pkg::CMD_BYTE: begin
                if (sel_high) begin
                    case (idx)
                        3'd0: begin
                            reply = cur_pos[15:8];
                            idx   = 3'd1;
                        end
                        3'd1: begin
                            reply = cur_pos[7:0];
                            idx   = 3'd2;
                        end
                        3'd2: begin
                            reply = {7'd0, mov};
                            idx   = 3'd0;
                        end
                        default: ;
                    endcase
                end else begin
                    if (idx < 3'd4) begin
                        frame[idx[1:0]] = b;
                        idx   = idx + 3'd1;
                        reply = {5'd0, idx};
                    end
                    if (idx == 3'd4) begin
                        if (frame[0] == spc_pkg::CODE_SET_TARGET) begin
                            reply   = spc_pkg::REPLY_TARGET;
                            tgt_pos = {frame[1], frame[2]};
                            pct     = frame[3];
                        end else if (frame[0] == spc_pkg::CODE_SET_CURRENT) begin
                            reply   = spc_pkg::REPLY_CURRENT;
                            cur_pos = {frame[1], frame[2]};
                            tgt_pos = {frame[1], frame[2]};
                        end
                    end
                end
            end
            spc_pkg::CMD_SELECT: begin
                if (s != sel_high) begin
                    sel_high = s;
                    idx      = '0;
                    frame    = '0;
                    if (s) begin
                        if (pct == 8'd0) begin
                            half = spc_pkg::HALF_PERIOD_MAX;
                        end else begin
                            quo  = numerator / pct;
                            half = (quo > 32'd65535) ? spc_pkg::HALF_PERIOD_MAX : quo[15:0];
                        end
                        if (cur_pos == tgt_pos) begin
                            mov = 1'b0;
                        end else begin
                            dir      = $signed(cur_pos) < $signed(tgt_pos);
                            ticks    = '0;
                            mov      = 1'b1;
                            timer_on = 1'b1;
                            drive    = 1'b1;
                        end
                    end else begin
                        halt_motor();
                    end
                end
            end
            spc_pkg::CMD_TICK: begin
                if (timer_on && sel_high) begin
                    if (ticks + 1 < half) begin
                        ticks = ticks + 17'd1;
                    end else begin
                        ticks = '0;
                        if (step) begin
                            step = 1'b0;
                        end else begin
                            step    = 1'b1;
                            cur_pos = dir ? cur_pos + 16'd1 : cur_pos - 16'd1;
                            if (cur_pos == tgt_pos)
                                halt_motor();
                        end
                    end
                end
            end
            default: ;
        endcase
        status_q.push_back(t_motor_status'{step, dir, drive, mov, reply, cur_pos});
    endfunction

    function void check_result(t_motor_status got);
        t_motor_status want;
        if (status_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: step=%0b dir=%0b en=%0b mov=%0b tx=%02h pos=%04h",
                         got.step, got.dir, got.enable, got.moving, got.tx, got.pos);
            return;
        end
        want = status_q.pop_front();
        if (want.step !== got.step || want.dir !== got.dir || want.enable !== got.enable
                || want.moving !== got.moving || want.tx !== got.tx || want.pos !== got.pos) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: expected step=%0b dir=%0b en=%0b mov=%0b tx=%02h pos=%04h",
                         want.step, want.dir, want.enable, want.moving, want.tx, want.pos);
                $display("          actual   step=%0b dir=%0b en=%0b mov=%0b tx=%02h pos=%04h",
                         got.step, got.dir, got.enable, got.moving, got.tx, got.pos);
            end
        end
    endfunction
endclass

module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         PHASE_ITEMS = 200;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [23:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  cmd       = '0;
    logic [7:0]  rx_byte   = '0;
    logic        sel_level = 1'b0;
    logic        out_ready = 1'b0;
    logic        calm      = 1'b0;
    int          items_sent = 0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_step_out;
    logic               o_direction_out;
    logic               o_motor_enable;
    logic               o_moving;
    logic [7:0]         o_tx_byte;
    logic signed [15:0] o_position;

    motor_scoreboard sb = new();

    stepper_position_controller i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (cmd),
        .i_rx_byte       (rx_byte),
        .i_select_level  (sel_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_step_out      (o_step_out),
        .o_direction_out (o_direction_out),
        .o_motor_enable  (o_motor_enable),
        .o_moving        (o_moving),
        .o_tx_byte       (o_tx_byte),
        .o_position      (o_position)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge clk) begin
        if (o_out_valid && out_ready)
            sb.check_result(t_motor_status'{o_step_out, o_direction_out, o_motor_enable,
                                            o_moving, o_tx_byte, o_position});
        out_ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic s);
        while (!calm && $urandom_range(0, 99) < 36) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        rx_byte   <= b;
        sel_level <= s;
        do @(posedge clk); while (!o_in_ready);
        sb.note_input(c, b, s);
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(spc_pkg::CMD_BYTE, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic set_select(input logic s);
        send_item(spc_pkg::CMD_SELECT, 8'($urandom), s);
    endtask

    task automatic tick();
        send_item(spc_pkg::CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_frame(input logic [7:0] code, input logic [15:0] value,
                              input logic [7:0] percent);
        send_byte(code);
        send_byte(value[15:8]);
        send_byte(value[7:0]);
        send_byte(percent);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_numerator(input logic [23:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        sb.numerator = value;
        cfg_we <= 1'b0;
    endtask

    // A move: set a nearby target, start, then tick until the motor stops or
    // an item cap is hit, with reads and an occasional select bounce mixed in.
    task automatic run_move();
        int          delta;
        int          cap;
        int          r;
        logic [15:0] target;
        logic [7:0]  percent;
        delta = $urandom_range(0, 24) - 12;
        r     = $urandom_range(0, 9);
        if (r == 0)
            percent = 8'd0;
        else if (r == 1)
            percent = 8'd255;
        else
            percent = 8'($urandom_range(1, 255));
        set_select(1'b0);
        target = sb.cur_pos + 16'(delta);
        send_frame(spc_pkg::CODE_SET_TARGET, target, percent);
        set_select(1'b1);
        cap = $urandom_range(40, 400);
        for (int n = 0; n < cap; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_byte(8'($urandom));
            else if (r < 10)
                set_select(1'b0);
            else if (r < 12)
                set_select(1'b1);
            else
                tick();
            if (!sb.mov && $urandom_range(0, 7) == 0)
                break;
        end
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    endtask

    task automatic run_set_current();
        logic [15:0] value;
        case ($urandom_range(0, 4))
            0:       value = 16'h7FFF - 16'($urandom_range(0, 6));
            1:       value = 16'h8000 + 16'($urandom_range(0, 6));
            2:       value = 16'hFFFF - 16'($urandom_range(0, 6));
            3:       value = 16'($urandom_range(0, 6));
            default: value = 16'($urandom);
        endcase
        set_select(1'b0);
        send_frame(spc_pkg::CODE_SET_CURRENT, value, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
        set_select(1'b1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    endtask

    task automatic run_broken_frame();
        int r;
        set_select(1'b0);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_byte(spc_pkg::CODE_SET_TARGET);
            else if (r < 7)
                send_byte(spc_pkg::CODE_SET_CURRENT);
            else
                send_byte(8'($urandom));
        end
        set_select(1'($urandom_range(0, 1)));
    endtask

    initial begin
        int          r;
        int          stop;
        logic [23:0] value;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_item(CMD_UNUSED, 8'hFF, 1'b1);
        set_select(1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        tick();
        set_select(1'b0);
        tick();
        send_frame(spc_pkg::CODE_SET_CURRENT, 16'h8000, 8'h00);
        send_byte(8'h11);
        set_select(1'b1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        set_select(1'b0);
        send_frame(spc_pkg::CODE_SET_TARGET, 16'h7FFF, 8'h00);
        set_select(1'b1);
        tick();
        set_select(1'b0);

        stop = items_sent;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1:       value = 24'd1;
                2:       value = 24'hFFFFFF;
                3:       value = 24'd200;
                4:       value = 24'd37;
                5:       value = 24'($urandom_range(2, 1000));
                6:       value = 24'd600;
                7:       value = 24'($urandom_range(1, 24'hFFFFFF));
                default: value = spc_pkg::NUM_RESET;
            endcase
            if (ph != 0)
                write_numerator(value);
            calm = (ph == 3);
            stop = stop + PHASE_ITEMS;
            while (items_sent < stop) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    run_move();
                end else if (r < 62) begin
                    run_set_current();
                end else if (r < 78) begin
                    run_broken_frame();
                end else begin
                    repeat ($urandom_range(3, 15))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom),
                                  1'($urandom_range(0, 1)));
                end
            end
        end
        calm = 1'b0;

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
